// ===== sv/escd_pkg.sv =====
// escd_pkg: shared types, character codes and helper functions of the
// backslash unescaper with Latin-1 to UTF-8 re-encoding.
// No dependencies.
`timescale 1ns / 1ps

package escd_pkg;

    // escape decoder phase
    typedef enum logic [1:0] {
        PH_PLAIN = 2'd0,
        PH_ESC   = 2'd1,
        PH_DIG1  = 2'd2,
        PH_DIG2  = 2'd3
    } escd_phase_t;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_N_LO      = 8'h6E;
    localparam logic [7:0] CH_N_UP      = 8'h4E;
    localparam logic [7:0] CH_T_LO      = 8'h74;
    localparam logic [7:0] CH_T_UP      = 8'h54;
    localparam logic [7:0] CH_R_LO      = 8'h72;
    localparam logic [7:0] CH_R_UP      = 8'h52;
    localparam logic [7:0] CH_A_LO      = 8'h61;
    localparam logic [7:0] CH_A_UP      = 8'h41;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_NINE      = 8'h39;

    // most decoded characters and UTF-8 bytes one item can give
    localparam int unsigned MAX_CHARS = 3;
    localparam int unsigned MAX_BYTES = 4;

    // decoded characters of one item plus the decoder state they leave
    typedef struct packed {
        logic [MAX_CHARS-1:0][7:0] chars;
        logic [1:0]                n;
        logic                      trunc;
        escd_phase_t               phase;
    } escd_acc_t;

    // UTF-8 bytes of one item
    typedef struct packed {
        logic [MAX_BYTES-1:0][7:0] bytes;
        logic [2:0]                nb;
    } escd_bytes_t;

    function automatic logic is_dec(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    function automatic logic [7:0] digit_char(input logic [3:0] d);
        return {4'h3, d};
    endfunction

    // append one decoded character; a zero ends the string
    function automatic escd_acc_t put_char(input escd_acc_t a, input logic [7:0] c);
        escd_acc_t r;
        r = a;
        if (!a.trunc) begin
            if (c == CH_NUL) begin
                r.trunc = 1'b1;
                r.phase = PH_PLAIN;
            end else if (a.n != 2'd3) begin
                r.chars[a.n] = c;
                r.n          = a.n + 2'd1;
            end
        end
        return r;
    endfunction

    // plain character: a backslash opens an escape
    function automatic escd_acc_t take_plain(input escd_acc_t a, input logic [7:0] c);
        escd_acc_t r;
        r = a;
        if (!a.trunc) begin
            if (c == CH_BACKSLASH) begin
                r.phase = PH_ESC;
            end else begin
                r = put_char(a, c);
            end
        end
        return r;
    endfunction

    // append one output byte, capped at the buffer depth
    function automatic escd_bytes_t push_byte(input escd_bytes_t b, input logic [7:0] v);
        escd_bytes_t r;
        r = b;
        if (b.nb < 3'(MAX_BYTES)) begin
            r.bytes[b.nb[1:0]] = v;
            r.nb               = b.nb + 3'd1;
        end
        return r;
    endfunction

endpackage

// ===== sv/escape_decode_latin1_to_utf8.sv =====
// escape_decode_latin1_to_utf8: an accepted item's first result is offered in
// the cycle after; results then leave one per cycle while m_tready is high,
// from a four-byte buffer. An item gives 0 to 4 results; a new item is taken
// only as the buffer empties, so items giving one result flow one per cycle
// likewise. Reset (aresetn low, synchronous) clears the decoder state and
// empties the result buffer. Depends on escd_pkg.
`timescale 1ns / 1ps

module escape_decode_latin1_to_utf8
    import escd_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tuser,   // [0] byte_valid
    output logic       m_tlast    // out_last
);

    escd_phase_t               phase_reg;
    logic [3:0]                first_digit_reg;
    logic [3:0]                second_digit_reg;
    logic                      trunc_reg;
    logic [MAX_BYTES-1:0][7:0] buf_reg;
    logic [2:0]                rem_reg;
    logic                      byte_valid_reg;
    logic                      last_reg;

    logic                      s_hs;
    logic                      m_hs;
    escd_acc_t                 acc;
    logic [3:0]                d1_next;
    logic [3:0]                d2_next;
    logic [9:0]                dec_value;
    escd_bytes_t               ob;
    logic                      marker;

    assign s_hs     = s_tvalid && s_tready;
    assign m_hs     = m_tvalid && m_tready;
    assign s_tready = (rem_reg == 3'd0) || ((rem_reg == 3'd1) && m_tready);

    // value of a three-digit escape
    assign dec_value = ({6'd0, first_digit_reg} * 10'd100)
                     + ({6'd0, second_digit_reg} * 10'd10)
                     + {6'd0, s_tdata[3:0]};

    // decode one character into up to three characters
    always_comb begin
        acc       = '0;
        acc.trunc = trunc_reg;
        acc.phase = phase_reg;
        d1_next   = first_digit_reg;
        d2_next   = second_digit_reg;
        if (!trunc_reg) begin
            unique case (phase_reg)
                PH_PLAIN: begin
                    acc = take_plain(acc, s_tdata);
                end
                PH_ESC: begin
                    acc.phase = PH_PLAIN;
                    if (s_tdata == CH_BACKSLASH) begin
                        acc = put_char(acc, CH_BACKSLASH);
                    end else if (s_tdata == CH_N_LO || s_tdata == CH_N_UP) begin
                        acc = put_char(acc, CH_LF);
                    end else if (s_tdata == CH_T_LO || s_tdata == CH_T_UP) begin
                        acc = put_char(acc, CH_TAB);
                    end else if (s_tdata == CH_R_LO || s_tdata == CH_R_UP) begin
                        acc = put_char(acc, CH_CR);
                    end else if (s_tdata == CH_A_LO || s_tdata == CH_A_UP) begin
                        acc = put_char(acc, CH_APOS);
                    end else if (is_dec(s_tdata)) begin
                        d1_next   = s_tdata[3:0];
                        acc.phase = PH_DIG1;
                    end else begin
                        acc = put_char(acc, s_tdata);
                    end
                end
                PH_DIG1: begin
                    if (is_dec(s_tdata)) begin
                        d2_next   = s_tdata[3:0];
                        acc.phase = PH_DIG2;
                    end else begin
                        acc.phase = PH_PLAIN;
                        acc       = put_char(acc, digit_char(first_digit_reg));
                        acc       = take_plain(acc, s_tdata);
                    end
                end
                PH_DIG2: begin
                    acc.phase = PH_PLAIN;
                    if (is_dec(s_tdata)) begin
                        acc = put_char(acc, dec_value[7:0]);
                    end else begin
                        acc = put_char(acc, digit_char(first_digit_reg));
                        acc = put_char(acc, digit_char(second_digit_reg));
                        acc = take_plain(acc, s_tdata);
                    end
                end
                default: begin
                    acc.phase = PH_PLAIN;
                end
            endcase
        end

        // flush a pending escape at the end of the string
        if (s_tlast && !acc.trunc) begin
            unique case (acc.phase)
                PH_ESC: begin
                    acc = put_char(acc, CH_BACKSLASH);
                end
                PH_DIG1: begin
                    acc = put_char(acc, digit_char(d1_next));
                end
                PH_DIG2: begin
                    acc = put_char(acc, digit_char(d1_next));
                    acc = put_char(acc, digit_char(d2_next));
                end
                default: begin
                end
            endcase
        end
    end

    // re-encode decoded characters as UTF-8 bytes
    always_comb begin
        ob = '0;
        for (int i = 0; i < MAX_CHARS; i++) begin
            if (2'(i) < acc.n) begin
                if (!acc.chars[i][7]) begin
                    ob = push_byte(ob, acc.chars[i]);
                end else begin
                    ob = push_byte(ob, {6'b110000, acc.chars[i][7:6]});
                    ob = push_byte(ob, {2'b10, acc.chars[i][5:0]});
                end
            end
        end
        marker = s_tlast && (ob.nb == 3'd0);
    end

    // decoder state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_PLAIN;
            first_digit_reg  <= 4'd0;
            second_digit_reg <= 4'd0;
            trunc_reg        <= 1'b0;
        end else if (s_hs) begin
            if (s_tlast) begin
                phase_reg        <= PH_PLAIN;
                first_digit_reg  <= 4'd0;
                second_digit_reg <= 4'd0;
                trunc_reg        <= 1'b0;
            end else begin
                phase_reg        <= acc.phase;
                first_digit_reg  <= d1_next;
                second_digit_reg <= d2_next;
                trunc_reg        <= acc.trunc;
            end
        end
    end

    // result buffer control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rem_reg        <= 3'd0;
            byte_valid_reg <= 1'b0;
            last_reg       <= 1'b0;
        end else if (s_hs) begin
            rem_reg        <= marker ? 3'd1 : ob.nb;
            byte_valid_reg <= !marker;
            last_reg       <= s_tlast;
        end else if (m_hs) begin
            rem_reg <= rem_reg - 3'd1;
        end
    end

    // result buffer bytes, shifted toward slot 0 as bytes leave
    always_ff @(posedge aclk) begin
        if (s_hs) begin
            buf_reg <= ob.bytes;
        end else if (m_hs) begin
            buf_reg <= {8'h00, buf_reg[MAX_BYTES-1:1]};
        end
    end

    assign m_tvalid = (rem_reg != 3'd0);
    assign m_tdata  = buf_reg[0];
    assign m_tuser  = byte_valid_reg;
    assign m_tlast  = last_reg && (rem_reg == 3'd1);

endmodule
